@@ sv/ptt_pkg.sv @@
// Package for the partition table translator.
// Holds the item structs, request and status codes and table constants.
// No dependencies.
package ptt_pkg;

  // table size, one cell per partition
  localparam int unsigned NumParts = 16;
  localparam int unsigned BlkW     = 64;
  localparam int unsigned IdW      = 8;

  localparam logic [BlkW-1:0] AllOnes = '1;

  // direction of a create
  localparam logic FromEnd = 1'b1;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_P2D    = 2'd1,
    REQ_D2P    = 2'd2,
    REQ_QUERY  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_EXISTS   = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_RANGE    = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FREE_BASE = 1'b0,
    REG_FREE_SIZE = 1'b1
  } cfg_reg_e;

  // input item
  typedef struct packed {
    req_type_e       req_type;
    logic [IdW-1:0]  part_id;
    logic            use_partition;
    logic [BlkW-1:0] block_number;
    logic [BlkW-1:0] carve_size;
    logic            carve_tail;
    logic [BlkW-1:0] base_block;
  } ptt_in_t;

  // result item
  typedef struct packed {
    status_e         status;
    logic [BlkW-1:0] result_block;
    logic [BlkW-1:0] part_offset;
    logic [BlkW-1:0] part_base;
    logic [BlkW-1:0] part_count;
    logic [BlkW-1:0] blocks_available;
  } ptt_out_t;

  // request fields broadcast to every cell
  typedef struct packed {
    req_type_e       req_type;
    logic [IdW-1:0]  part_id;
    logic [BlkW-1:0] block_number;
  } ptt_cell_req_t;

  // one table entry
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [BlkW-1:0] offset;
    logic [BlkW-1:0] base;
    logic [BlkW-1:0] count;
  } ptt_entry_t;

  // match result collected along the cell row
  typedef struct packed {
    logic            hit;
    logic            below;
    logic [BlkW-1:0] diff;
    logic [BlkW-1:0] offset;
    logic [BlkW-1:0] base;
    logic [BlkW-1:0] count;
  } ptt_acc_t;

endpackage

@@ sv/ptt_cell.sv @@
// One cell of the partition table row: holds one entry, matches the id of
// the current item and merges its hit into the result passed down the row.
// Depends on ptt_pkg.
module ptt_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clear_i,
  input  ptt_pkg::ptt_cell_req_t req_i,
  input  logic                   wr_en_i,
  input  ptt_pkg::ptt_entry_t    wr_entry_i,
  input  logic                   prev_valid_i,
  output logic                   valid_o,
  input  ptt_pkg::ptt_acc_t      acc_i,
  output ptt_pkg::ptt_acc_t      acc_o,
  output logic                   hit_o
);
  import ptt_pkg::*;

  logic              valid_q, valid_d;
  ptt_entry_t        entry_q;
  logic              hit_q, hit_d;
  logic              below_q, below_d;
  logic [BlkW-1:0]   diff_q, diff_d;
  logic [BlkW-1:0]   from_blk;
  logic              take;

  // first free cell of the row takes the new entry
  assign take = wr_en_i && !valid_q && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (take) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q <= wr_entry_i;
    end
  end

  // id match and distance from the partition start
  always_comb begin
    from_blk = (req_i.req_type == REQ_P2D) ? entry_q.base : entry_q.offset;
    hit_d    = valid_q && (entry_q.id == req_i.part_id);
    below_d  = req_i.block_number < from_blk;
    diff_d   = req_i.block_number - from_blk;
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    below_q <= below_d;
    diff_q  <= diff_d;
  end

  // merge into the row result, ids are unique so at most one cell hits
  always_comb begin
    acc_o = acc_i;
    if (hit_q) begin
      acc_o.hit    = 1'b1;
      acc_o.below  = acc_i.below | below_q;
      acc_o.diff   = acc_i.diff | diff_q;
      acc_o.offset = acc_i.offset | entry_q.offset;
      acc_o.base   = acc_i.base | entry_q.base;
      acc_o.count  = acc_i.count | entry_q.count;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

@@ sv/partition_table_translator.sv @@
// Partition table translator: a row of 16 table cells holds the partitions
// carved from one free block range. An item is accepted, matched against all
// cells in the match state and resolved in the resolve state, which holds
// while the result register is full and stalled; a new item is taken only as
// the last one leaves the resolve state, so one item at a time passes through
// the cell row. Writing either layout register (first free block or free
// block total) empties the table and resets the free range at once.
// Depends on ptt_pkg and ptt_cell.
module partition_table_translator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  ptt_pkg::cfg_reg_e           cfg_idx_i,
  input  logic [ptt_pkg::BlkW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ptt_pkg::ptt_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ptt_pkg::ptt_out_t           out_data_o
);
  import ptt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_MATCH   = 3'b010,
    S_RESOLVE = 3'b100
  } state_e;

  state_e          state_q, state_d;
  ptt_in_t         req_q;
  logic [BlkW-1:0] start_q, total_q;
  logic [BlkW-1:0] free_first_q, free_last_q, avail_q;
  logic            out_valid_q;
  ptt_out_t        out_q;
  ptt_out_t        res;

  logic            in_acc, done, create_ok;
  logic [BlkW-1:0] cnt_sel, new_off;
  logic            no_space, full;

  ptt_cell_req_t   cell_req;
  ptt_entry_t      wr_entry;
  ptt_acc_t        acc     [NumParts+1];
  logic            chain_v [NumParts+1];
  logic [NumParts-1:0] cell_hit, cell_valid;

  // handshake and sequencing
  assign done       = (state_q == S_RESOLVE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == S_IDLE) || done);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_acc) state_d = S_MATCH;
      S_MATCH:   state_d = S_RESOLVE;
      S_RESOLVE: if (done) state_d = in_acc ? S_MATCH : S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
  end

  // row of table cells
  assign cell_req.req_type     = req_q.req_type;
  assign cell_req.part_id      = req_q.part_id;
  assign cell_req.block_number = req_q.block_number;

  assign wr_entry.id     = req_q.part_id;
  assign wr_entry.offset = new_off;
  assign wr_entry.base   = req_q.base_block;
  assign wr_entry.count  = cnt_sel;

  assign acc[0]     = '0;
  assign chain_v[0] = 1'b1;

  for (genvar i = 0; i < NumParts; i++) begin : g_cell
    ptt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .clear_i      (cfg_we_i),
      .req_i        (cell_req),
      .wr_en_i      (done && create_ok),
      .wr_entry_i   (wr_entry),
      .prev_valid_i (chain_v[i]),
      .valid_o      (chain_v[i+1]),
      .acc_i        (acc[i]),
      .acc_o        (acc[i+1]),
      .hit_o        (cell_hit[i])
    );
    assign cell_valid[i] = chain_v[i+1];
  end

  assign full = chain_v[NumParts];

  // resolve the item from the row result and the free range
  always_comb begin
    cnt_sel   = (req_q.carve_size == AllOnes) ? avail_q : req_q.carve_size;
    no_space  = (req_q.carve_size == AllOnes) ? (avail_q == '0)
                                              : (req_q.carve_size > avail_q);
    new_off   = (req_q.carve_tail == FromEnd) ? (free_last_q - cnt_sel) : free_first_q;
    create_ok = 1'b0;
    res       = '0;
    res.status = ST_OK;
    unique case (req_q.req_type)
      REQ_CREATE: begin
        priority if (no_space) begin
          res.status = ST_NO_SPACE;
        end else if (acc[NumParts].hit) begin
          res.status = ST_EXISTS;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          create_ok       = 1'b1;
          res.part_offset = new_off;
          res.part_base   = req_q.base_block;
          res.part_count  = cnt_sel;
        end
      end
      REQ_P2D, REQ_D2P: begin
        priority if (!req_q.use_partition) begin
          res.result_block = req_q.block_number;
        end else if (!acc[NumParts].hit) begin
          res.status = ST_UNKNOWN;
        end else if (acc[NumParts].below ||
                     (acc[NumParts].diff >= acc[NumParts].count)) begin
          res.status = ST_RANGE;
        end else begin
          res.result_block = ((req_q.req_type == REQ_P2D) ? acc[NumParts].offset
                                                          : acc[NumParts].base)
                             + acc[NumParts].diff;
        end
      end
      REQ_QUERY: begin
        if (!acc[NumParts].hit) begin
          res.status = ST_UNKNOWN;
        end else begin
          res.part_offset = acc[NumParts].offset;
          res.part_base   = acc[NumParts].base;
          res.part_count  = acc[NumParts].count;
        end
      end
      default: res.status = ST_OK;
    endcase
    res.blocks_available = create_ok ? (avail_q - cnt_sel) : avail_q;
  end

  // configuration and free range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= '0;
      total_q      <= '0;
      free_first_q <= '0;
      free_last_q  <= '0;
      avail_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FREE_BASE: begin
          start_q      <= cfg_wdata_i;
          free_first_q <= cfg_wdata_i;
          free_last_q  <= cfg_wdata_i + total_q;
          avail_q      <= total_q;
        end
        REG_FREE_SIZE: begin
          total_q      <= cfg_wdata_i;
          free_first_q <= start_q;
          free_last_q  <= start_q + cfg_wdata_i;
          avail_q      <= cfg_wdata_i;
        end
        default: begin
          start_q <= start_q;
        end
      endcase
    end else if (done && create_ok) begin
      avail_q <= avail_q - cnt_sel;
      if (req_q.carve_tail == FromEnd) begin
        free_last_q <= free_last_q - cnt_sel;
      end else begin
        free_first_q <= free_first_q + cnt_sel;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a new result only comes out of the resolve step
  a_result_from_resolve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESOLVE))
    else $error("result appeared without a resolve step");

  // ids in the table are unique, so at most one cell matches
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESOLVE) |-> $onehot0(cell_hit))
    else $error("more than one cell matched the id");

  // cells fill from the front of the row with no gaps
  a_packed_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (({1'b0, cell_valid} + {{NumParts{1'b0}}, 1'b1}) & {1'b0, cell_valid}) == '0)
    else $error("valid cells are not contiguous");

  // a create that succeeds takes blocks from the free count
  a_create_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && create_ok && !cfg_we_i) |=> (avail_q == $past(avail_q - cnt_sel)))
    else $error("free count not reduced by a create");

endmodule

@@ tb/partition_table_translator_test.sv @@
// Self-checking testbench for partition_table_translator: random and directed
// requests checked against an in-bench model of the partition table.
// Depends on ptt_pkg and the partition_table_translator RTL.
module partition_table_translator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam logic FromFront = ~FromEnd;
  localparam int unsigned LongHold = 300;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned PrintCap = 50;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_reg_e cfg_idx_i = REG_FREE_BASE;
  logic [BlkW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ptt_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ptt_out_t out_data_o;

  partition_table_translator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // model of the partition table
  logic            tbl_valid  [NumParts];
  logic [IdW-1:0]  tbl_id     [NumParts];
  logic [BlkW-1:0] tbl_offset [NumParts];
  logic [BlkW-1:0] tbl_base   [NumParts];
  logic [BlkW-1:0] tbl_count  [NumParts];
  logic [BlkW-1:0] layout_start = '0;
  logic [BlkW-1:0] layout_total = '0;
  logic [BlkW-1:0] free_first = '0;
  logic [BlkW-1:0] free_last = '0;

  ptt_in_t  pending_reqs [$];
  ptt_out_t block_results [$];
  ptt_out_t exp_result;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;
  logic [IdW-1:0] id_base = '0;

  initial begin
    for (int i = 0; i < NumParts; i++) begin
      tbl_valid[i] = 1'b0;
    end
  end

  // register write empties the table and reopens the free range
  function automatic void set_layout_reg(cfg_reg_e idx, logic [BlkW-1:0] val);
    if (idx == REG_FREE_BASE) begin
      layout_start = val;
    end else begin
      layout_total = val;
    end
    for (int i = 0; i < NumParts; i++) begin
      tbl_valid[i] = 1'b0;
    end
    free_first = layout_start;
    free_last  = layout_start + layout_total;
  endfunction

  function automatic int find_part(logic [IdW-1:0] id);
    for (int i = 0; i < NumParts; i++) begin
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // expected result of one request, updating the model table
  function automatic ptt_out_t translate_request(ptt_in_t rq);
    ptt_out_t rs;
    logic [BlkW-1:0] free_now, cnt, from_blk, to_blk, off;
    int slot;
    rs = '0;
    rs.status = ST_OK;
    if (rq.req_type == REQ_CREATE) begin
      free_now = free_last - free_first;
      cnt = rq.carve_size;
      // space check comes first, all ones takes the whole free range
      if (cnt == AllOnes) begin
        if (free_now == '0) rs.status = ST_NO_SPACE;
        else cnt = free_now;
      end else if (cnt > free_now) begin
        rs.status = ST_NO_SPACE;
      end
      if (rs.status == ST_OK && find_part(rq.part_id) >= 0) rs.status = ST_EXISTS;
      slot = -1;
      if (rs.status == ST_OK) begin
        for (int i = NumParts - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) slot = i;
        end
        if (slot < 0) rs.status = ST_FULL;
      end
      if (rs.status == ST_OK) begin
        off = (rq.carve_tail == FromEnd) ? free_last - cnt : free_first;
        tbl_valid[slot]  = 1'b1;
        tbl_id[slot]     = rq.part_id;
        tbl_offset[slot] = off;
        tbl_base[slot]   = rq.base_block;
        tbl_count[slot]  = cnt;
        if (rq.carve_tail == FromEnd) free_last = free_last - cnt;
        else free_first = free_first + cnt;
        rs.part_offset = off;
        rs.part_base   = rq.base_block;
        rs.part_count  = cnt;
      end
    end else if ((rq.req_type == REQ_P2D || rq.req_type == REQ_D2P) && !rq.use_partition) begin
      rs.result_block = rq.block_number;
    end else begin
      slot = find_part(rq.part_id);
      if (slot < 0) begin
        rs.status = ST_UNKNOWN;
      end else if (rq.req_type == REQ_QUERY) begin
        rs.part_offset = tbl_offset[slot];
        rs.part_base   = tbl_base[slot];
        rs.part_count  = tbl_count[slot];
      end else begin
        from_blk = (rq.req_type == REQ_P2D) ? tbl_base[slot] : tbl_offset[slot];
        to_blk   = (rq.req_type == REQ_P2D) ? tbl_offset[slot] : tbl_base[slot];
        if (rq.block_number < from_blk || rq.block_number - from_blk >= tbl_count[slot]) begin
          rs.status = ST_RANGE;
        end else begin
          rs.result_block = to_blk + (rq.block_number - from_blk);
        end
      end
    end
    rs.blocks_available = free_last - free_first;
    return rs;
  endfunction

  function automatic logic [BlkW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random request, steered toward live partitions and range edges
  function automatic ptt_in_t make_random_request();
    ptt_in_t rq;
    int unsigned pick, sel;
    int slot;
    logic [BlkW-1:0] span, lo;
    rq = '0;
    rq.req_type      = REQ_QUERY;
    rq.part_id       = id_base + IdW'($urandom_range(0, 19));
    rq.use_partition = 1'b1;
    rq.block_number  = rand64();
    rq.carve_size    = rand64();
    rq.carve_tail    = 1'($urandom_range(0, 1));
    rq.base_block    = rand64();
    if ($urandom_range(0, 9) == 0) rq.part_id = IdW'($urandom);
    pick = $urandom_range(0, 99);
    slot = $urandom_range(0, NumParts - 1);
    if (pick < 25) begin
      // create with sizes around the free count
      rq.req_type = REQ_CREATE;
      rq.use_partition = 1'($urandom_range(0, 1));
      span = free_last - free_first;
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2, 3, 4: rq.carve_size = rand64() % (span / 8 + 1);
        5: rq.carve_size = AllOnes;
        6: rq.carve_size = '0;
        7: rq.carve_size = span;
        8: rq.carve_size = span + 1;
        default: ;
      endcase
      if ($urandom_range(0, 1)) rq.base_block = BlkW'($urandom_range(0, 4095));
    end else if (pick < 75) begin
      // translate through a partition
      rq.req_type = $urandom_range(0, 1) ? REQ_P2D : REQ_D2P;
      if (tbl_valid[slot] && $urandom_range(0, 4) != 0) begin
        rq.part_id = tbl_id[slot];
        lo = (rq.req_type == REQ_P2D) ? tbl_base[slot] : tbl_offset[slot];
        sel = $urandom_range(0, 7);
        case (sel)
          0: rq.block_number = lo;
          1: rq.block_number = lo + tbl_count[slot] - 1;
          2: rq.block_number = lo + tbl_count[slot];
          3: rq.block_number = lo - 1;
          default: begin
            if (tbl_count[slot] == '0) rq.block_number = lo;
            else rq.block_number = lo + rand64() % tbl_count[slot];
          end
        endcase
      end
    end else if (pick < 85) begin
      // pass-through translation
      rq.req_type = $urandom_range(0, 1) ? REQ_P2D : REQ_D2P;
      rq.use_partition = 1'b0;
    end else begin
      rq.req_type = REQ_QUERY;
      rq.use_partition = 1'($urandom_range(0, 1));
      if (tbl_valid[slot] && $urandom_range(0, 3) != 0) rq.part_id = tbl_id[slot];
    end
    return rq;
  endfunction

  task automatic push_req(req_type_e kind, logic [IdW-1:0] id, logic use_p,
                          logic [BlkW-1:0] num, logic [BlkW-1:0] cnt, logic dir,
                          logic [BlkW-1:0] base);
    ptt_in_t rq;
    rq.req_type      = kind;
    rq.part_id       = id;
    rq.use_partition = use_p;
    rq.block_number  = num;
    rq.carve_size    = cnt;
    rq.carve_tail    = dir;
    rq.base_block    = base;
    pending_reqs.push_back(rq);
  endtask

  task automatic note_mismatch(string msg);
    if (mismatch_count < PrintCap) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [BlkW-1:0] got, logic [BlkW-1:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // both registers written back to back while the block is idle
  task automatic write_layout(logic [BlkW-1:0] start, logic [BlkW-1:0] total);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FREE_BASE;
    cfg_wdata_i <= start;
    set_layout_reg(REG_FREE_BASE, start);
    @(posedge clk_i);
    cfg_idx_i   <= REG_FREE_SIZE;
    cfg_wdata_i <= total;
    set_layout_reg(REG_FREE_SIZE, total);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // every queued item sent and every result back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || block_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // request driver, predicts each accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) block_results.push_back(translate_request(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_reqs.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result stall, with an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_seen   <= 0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= LongHold;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (block_results.size() == 0) begin
        note_mismatch("result item with nothing outstanding");
      end else begin
        exp_result = block_results.pop_front();
        check_field("status", BlkW'(out_data_o.status), BlkW'(exp_result.status));
        check_field("result_block", out_data_o.result_block, exp_result.result_block);
        check_field("part_offset", out_data_o.part_offset, exp_result.part_offset);
        check_field("part_base", out_data_o.part_base, exp_result.part_base);
        check_field("part_count", out_data_o.part_count, exp_result.part_count);
        check_field("blocks_available", out_data_o.blocks_available,
                    exp_result.blocks_available);
      end
    end
  end

  // stimulus sequence
  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty layout after reset: only a zero-sized create fits
    push_req(REQ_CREATE, 8'd7, 1'b0, '0, AllOnes, FromFront, '0);
    push_req(REQ_CREATE, 8'd7, 1'b0, '0, '0, FromFront, 64'd5);
    push_req(REQ_QUERY, 8'd7, 1'b1, '0, '0, FromFront, '0);
    push_req(REQ_P2D, 8'd7, 1'b1, 64'd5, '0, FromFront, '0);
    wait_drained();

    // front and end carving, range edges, unknown ids, pass-through
    write_layout(64'd1000, 64'd100);
    push_req(REQ_CREATE, 8'd1, 1'b1, '0, 64'd10, FromFront, '0);
    push_req(REQ_CREATE, 8'd1, 1'b1, '0, 64'd5, FromFront, '0);
    push_req(REQ_CREATE, 8'd2, 1'b1, '0, 64'd200, FromEnd, '0);
    push_req(REQ_CREATE, 8'd2, 1'b1, '0, 64'd20, FromEnd, 64'd500);
    push_req(REQ_P2D, 8'd1, 1'b1, 64'd0, '0, FromFront, '0);
    push_req(REQ_P2D, 8'd1, 1'b1, 64'd9, '0, FromFront, '0);
    push_req(REQ_P2D, 8'd1, 1'b1, 64'd10, '0, FromFront, '0);
    push_req(REQ_D2P, 8'd2, 1'b1, 64'd1079, '0, FromFront, '0);
    push_req(REQ_D2P, 8'd2, 1'b1, 64'd1099, '0, FromFront, '0);
    push_req(REQ_D2P, 8'd2, 1'b1, 64'd1100, '0, FromFront, '0);
    push_req(REQ_P2D, 8'd255, 1'b0, AllOnes, AllOnes, FromEnd, AllOnes);
    push_req(REQ_D2P, 8'd0, 1'b0, 64'h5555_aaaa_5555_aaaa, '0, FromFront, '0);
    push_req(REQ_QUERY, 8'd2, 1'b0, '0, '0, FromFront, '0);
    push_req(REQ_QUERY, 8'd99, 1'b1, '0, '0, FromFront, '0);
    push_req(REQ_P2D, 8'd77, 1'b1, 64'd3, '0, FromFront, '0);
    push_req(REQ_CREATE, 8'd4, 1'b0, '0, AllOnes, FromEnd, AllOnes);
    push_req(REQ_CREATE, 8'd5, 1'b0, '0, AllOnes, FromFront, '0);
    push_req(REQ_CREATE, 8'd5, 1'b0, '0, '0, FromFront, '0);
    wait_drained();

    // everything at the top of the block space, wrapping arithmetic
    write_layout(AllOnes, AllOnes);
    push_req(REQ_CREATE, 8'd9, 1'b1, '0, AllOnes, FromEnd, 64'd16);
    push_req(REQ_P2D, 8'd9, 1'b1, AllOnes, '0, FromFront, '0);
    push_req(REQ_D2P, 8'd9, 1'b1, 64'd3, '0, FromFront, '0);
    wait_drained();

    // random phases over layouts and idling patterns
    for (int ph = 0; ph < 11; ph++) begin
      case (ph % 5)
        0: write_layout(BlkW'($urandom), BlkW'($urandom_range(1000, 1999)));
        1: write_layout(AllOnes - BlkW'($urandom_range(0, 15)), AllOnes);
        2: write_layout('0, '0);
        3: write_layout(rand64(), rand64());
        default: write_layout(BlkW'($urandom_range(0, 65535)), 64'd48);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      id_base = IdW'($urandom);
      for (int n = 0; n < PhaseItems; n++) begin
        while (pending_reqs.size() > 2) @(negedge clk_i);
        // long receiver hold while requests keep coming
        if (ph == 4 && n == 40) hold_req++;
        // sender pause until the block has drained
        if (ph == 8 && n == 75) wait_drained();
        pending_reqs.push_back(make_random_request());
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (block_results.size() != 0) note_mismatch("results still outstanding at end");
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
